// ===== rtl/console_capture_panic_detector_top_assert.svh =====
// Assertion macros shared by the console capture RTL.
// Depends on aclk and aresetn being present in the including module.
`ifndef CONSOLE_CAPTURE_PANIC_DETECTOR_TOP_ASSERT_SVH
`define CONSOLE_CAPTURE_PANIC_DETECTOR_TOP_ASSERT_SVH

// check a condition at every clock edge outside reset
`define CCPD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// check a consequence in the cycle after an antecedent
`define CCPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ccpd_pkg.sv =====
// Shared types and constants of the console capture panic detector.
// No dependencies.
`default_nettype none

package ccpd_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  wdata;
        logic        read_valid;
        logic [14:0] stored_length;
        logic        was_truncated;
        logic        panic_present;
    } entry_t;

    localparam logic [14:0] LIMIT_RESET = 15'd16384;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    localparam int SIG_COUNT = 6;
    localparam int SIG_MAX   = 34;

    // text right-aligned: last character in the low byte
    localparam logic [SIG_MAX*8-1:0] SIG_TEXT [SIG_COUNT] = '{
        "Illegal instruction in kernel mode",
        "no fault handler for frame",
        "assertion ",
        "kernel panic",
        "Kernel panic",
        "PANIC"
    };

    localparam int unsigned SIG_LEN [SIG_COUNT] = '{34, 26, 10, 12, 12, 5};

endpackage

`default_nettype wire

// ===== rtl/ccpd_front.sv =====
// Front end: decodes commands, keeps window state, history and signature match.
// Depends on ccpd_pkg; issues store operations to ccpd_queue.
`default_nettype none

module ccpd_front #(
    parameter int CAPTURE_DEPTH = 16384,
    parameter int HISTORY_BYTES = 34,
    parameter int AW = $clog2(CAPTURE_DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [14:0]       cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        in_cmd,
    input  wire logic [7:0]        in_byte,
    input  wire logic [13:0]       in_offset,
    input  wire logic              q_full,
    output logic                   q_push,
    output ccpd_pkg::entry_t       q_entry,
    output logic [AW-1:0]          q_addr
);

    `include "console_capture_panic_detector_top_assert.svh"

    localparam int CW   = $clog2(CAPTURE_DEPTH + 1);
    localparam int SW   = $clog2(CAPTURE_DEPTH + 2);
    localparam int WW   = (CW > 15) ? CW : 15;
    localparam int SUMW = ((CW > 14) ? CW : 14) + 1;
    localparam logic [SUMW-1:0] DEPTH_S = SUMW'(CAPTURE_DEPTH);
    localparam logic [WW-1:0]   DEPTH_W = WW'(CAPTURE_DEPTH);
    localparam logic [SW-1:0]   DEPTH_SP = SW'(CAPTURE_DEPTH);

    logic [14:0]   limit_reg;
    logic [AW-1:0] oldest_reg, oldest_next;
    logic [CW-1:0] held_reg, held_next;
    logic          dropped_reg, dropped_next;
    logic [7:0]    hist_reg [HISTORY_BYTES];
    logic [7:0]    hist_next [HISTORY_BYTES];
    logic [7:0]    hist_shift [HISTORY_BYTES];
    logic          seen_reg, seen_next;
    logic [SW-1:0] span_reg, span_next;

    ccpd_pkg::cmd_t cmd;
    logic [CW-1:0]   lim;
    logic [WW-1:0]   lim_w;
    logic [SUMW-1:0] addr_sum, addr_wrap, drop_sum, drop_wrap;
    logic            rd_ok;
    logic [ccpd_pkg::SIG_COUNT-1:0] hit;
    logic            accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;
    assign cmd      = ccpd_pkg::cmd_t'(in_cmd);

    always_comb begin
        lim_w = (WW'(limit_reg) > DEPTH_W) ? DEPTH_W : WW'(limit_reg);
        lim   = lim_w[CW-1:0];
        rd_ok = SUMW'(in_offset) < SUMW'(held_reg);
        addr_sum = SUMW'(oldest_reg)
                 + ((cmd == ccpd_pkg::CMD_PUSH) ? SUMW'(held_reg) : SUMW'(in_offset));
        addr_wrap = (addr_sum >= DEPTH_S) ? addr_sum - DEPTH_S : addr_sum;
        drop_sum  = SUMW'(oldest_reg) + SUMW'(held_reg) - SUMW'(lim) + SUMW'(1);
        drop_wrap = (drop_sum >= DEPTH_S) ? drop_sum - DEPTH_S : drop_sum;
    end

    always_comb begin
        for (int i = 0; i < HISTORY_BYTES - 1; i++) begin
            hist_shift[i] = hist_reg[i+1];
        end
        hist_shift[HISTORY_BYTES-1] = in_byte;
        for (int s = 0; s < ccpd_pkg::SIG_COUNT; s++) begin
            hit[s] = 1'b1;
            for (int j = 0; j < ccpd_pkg::SIG_MAX; j++) begin
                if (j < ccpd_pkg::SIG_LEN[s]) begin
                    if (hist_shift[HISTORY_BYTES-1-j] != ccpd_pkg::SIG_TEXT[s][j*8 +: 8]) begin
                        hit[s] = 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        oldest_next  = oldest_reg;
        held_next    = held_reg;
        dropped_next = dropped_reg;
        hist_next    = hist_reg;
        seen_next    = seen_reg;
        span_next    = span_reg;
        q_entry.op         = ccpd_pkg::OP_NONE;
        q_entry.wdata      = in_byte;
        q_entry.read_valid = 1'b0;
        q_addr             = addr_wrap[AW-1:0];
        unique case (cmd)
            ccpd_pkg::CMD_PUSH: begin
                if (lim != '0) begin
                    q_entry.op = ccpd_pkg::OP_WRITE;
                    if (held_reg >= lim) begin
                        oldest_next  = drop_wrap[AW-1:0];
                        held_next    = lim;
                        dropped_next = 1'b1;
                    end else begin
                        held_next = held_reg + CW'(1);
                    end
                    hist_next = hist_shift;
                    if (seen_reg && span_reg <= DEPTH_SP) begin
                        span_next = span_reg + SW'(1);
                    end
                    for (int s = 0; s < ccpd_pkg::SIG_COUNT; s++) begin
                        if (hit[s]) begin
                            if (!seen_next || SW'(ccpd_pkg::SIG_LEN[s]) < span_next) begin
                                span_next = SW'(ccpd_pkg::SIG_LEN[s]);
                            end
                            seen_next = 1'b1;
                        end
                    end
                end
            end
            ccpd_pkg::CMD_READ: begin
                if (rd_ok) begin
                    q_entry.op         = ccpd_pkg::OP_READ;
                    q_entry.read_valid = 1'b1;
                end
            end
            ccpd_pkg::CMD_CLEAR: begin
                oldest_next  = '0;
                held_next    = '0;
                dropped_next = 1'b0;
                for (int i = 0; i < HISTORY_BYTES; i++) begin
                    hist_next[i] = 8'd0;
                end
                seen_next = 1'b0;
                span_next = '0;
            end
            default: begin
            end
        endcase
        q_entry.stored_length = 15'(held_next);
        q_entry.was_truncated = dropped_next;
        q_entry.panic_present = seen_next && (span_next <= SW'(held_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= ccpd_pkg::LIMIT_RESET;
            oldest_reg  <= '0;
            held_reg    <= '0;
            dropped_reg <= 1'b0;
            seen_reg    <= 1'b0;
            span_reg    <= '0;
            for (int i = 0; i < HISTORY_BYTES; i++) begin
                hist_reg[i] <= 8'd0;
            end
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (accept) begin
                oldest_reg  <= oldest_next;
                held_reg    <= held_next;
                dropped_reg <= dropped_next;
                seen_reg    <= seen_next;
                span_reg    <= span_next;
                hist_reg    <= hist_next;
            end
        end
    end

    `CCPD_ASSERT_ALWAYS(a_held_bound, SUMW'(held_reg) <= DEPTH_S, "held count above depth")
    `CCPD_ASSERT_NEXT(a_clear_empties, accept && cmd == ccpd_pkg::CMD_CLEAR,
        held_reg == '0 && !seen_reg && !dropped_reg, "clear left state behind")

endmodule

`default_nettype wire

// ===== rtl/ccpd_queue.sv =====
// Short operation queue between the front end and the store back end.
// Depends on ccpd_pkg.
`default_nettype none

module ccpd_queue #(
    parameter int AW = 14
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  ccpd_pkg::entry_t      push_entry,
    input  wire logic [AW-1:0]    push_addr,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output ccpd_pkg::entry_t      head_entry,
    output logic [AW-1:0]         head_addr
);

    `include "console_capture_panic_detector_top_assert.svh"

    ccpd_pkg::entry_t ent_mem [ccpd_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    addr_mem [ccpd_pkg::QUEUE_DEPTH];
    logic [ccpd_pkg::QPW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [ccpd_pkg::QCW-1:0] count_reg, count_next;
    logic do_pop;

    assign full       = count_reg == ccpd_pkg::QCW'(ccpd_pkg::QUEUE_DEPTH);
    assign not_empty  = count_reg != '0;
    assign do_pop     = pop && not_empty;
    assign head_entry = ent_mem[rd_ptr_reg];
    assign head_addr  = addr_mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + ccpd_pkg::QCW'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - ccpd_pkg::QCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_mem[wr_ptr_reg]  <= push_entry;
            addr_mem[wr_ptr_reg] <= push_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + ccpd_pkg::QPW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + ccpd_pkg::QPW'(1);
            end
            count_reg <= count_next;
        end
    end

    `CCPD_ASSERT_ALWAYS(a_no_overflow, !(push && full), "push into full queue")

endmodule

`default_nettype wire

// ===== rtl/ccpd_back.sv =====
// Back end: capture store access and the registered result beat.
// Depends on ccpd_pkg; drains ccpd_queue.
`default_nettype none

module ccpd_back #(
    parameter int CAPTURE_DEPTH = 16384,
    parameter int AW = $clog2(CAPTURE_DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_not_empty,
    input  ccpd_pkg::entry_t      q_entry,
    input  wire logic [AW-1:0]    q_addr,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [31:0]           m_tdata
);

    `include "console_capture_panic_detector_top_assert.svh"

    logic [7:0]       store [CAPTURE_DEPTH];
    logic [7:0]       rdata_reg;
    logic             out_valid_reg;
    ccpd_pkg::entry_t out_ent_reg;
    logic [7:0]       read_data;

    assign q_pop    = q_not_empty && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign read_data = (out_ent_reg.op == ccpd_pkg::OP_READ) ? rdata_reg : 8'd0;
    assign m_tdata  = {6'd0, out_ent_reg.panic_present, out_ent_reg.was_truncated,
                       out_ent_reg.stored_length, out_ent_reg.read_valid, read_data};

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            if (q_entry.op == ccpd_pkg::OP_WRITE) begin
                store[q_addr] <= q_entry.wdata;
            end
            if (q_entry.op == ccpd_pkg::OP_READ) begin
                rdata_reg <= store[q_addr];
            end
            out_ent_reg <= q_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    `CCPD_ASSERT_NEXT(a_pop_loads_beat, q_pop, out_valid_reg, "popped entry not presented")

endmodule

`default_nettype wire

// ===== rtl/console_capture_panic_detector_top.sv =====
// Top level of the console capture panic detector.
// Depends on ccpd_pkg, ccpd_front, ccpd_queue and ccpd_back.
//
//   channel  dir  handshake            payload
//   s_       in   s_tvalid/s_tready    s_tdata: console_byte, read_offset; s_tuser: cmd
//   m_       out  m_tvalid/m_tready    m_tdata: read_data ... panic_present
//   cfg_     in   cfg_wr_en            cfg_wr_data: capture_limit
//
// One item per cycle while the queue has room; each item yields one result beat.
// Front updates window state in the accept cycle; the single store port in the back
// end performs at most one write or read per cycle, in item order.
// A four-entry queue absorbs output stalls; s_tready drops only when it is full.
// Reset is synchronous and immediate; store contents are undefined until written.
`default_nettype none

module console_capture_panic_detector_top #(
    parameter int CAPTURE_DEPTH = 16384,
    parameter int HISTORY_BYTES = 34
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [14:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // console_byte[7:0], read_offset[21:8], zero[23:22]
    input  wire logic [1:0]  s_tuser,   // cmd[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // read_data[7:0], read_valid[8], stored_length[23:9],
                                        // was_truncated[24], panic_present[25], zero[31:26]
);

    localparam int AW = $clog2(CAPTURE_DEPTH);

    logic             q_full, q_push, q_pop, q_not_empty;
    ccpd_pkg::entry_t push_entry, head_entry;
    logic [AW-1:0]    push_addr, head_addr;

    ccpd_front #(
        .CAPTURE_DEPTH (CAPTURE_DEPTH),
        .HISTORY_BYTES (HISTORY_BYTES),
        .AW            (AW)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser),
        .in_byte     (s_tdata[7:0]),
        .in_offset   (s_tdata[21:8]),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry),
        .q_addr      (push_addr)
    );

    ccpd_queue #(
        .AW (AW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .push_addr  (push_addr),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head_entry (head_entry),
        .head_addr  (head_addr)
    );

    ccpd_back #(
        .CAPTURE_DEPTH (CAPTURE_DEPTH),
        .AW            (AW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_entry     (head_entry),
        .q_addr      (head_addr),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

// ===== tb/tb_console_capture_panic_detector_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for console_capture_panic_detector_top: capture window, reads by age,
// clear, truncation and panic signature tracking. Depends on ccpd_pkg and the top level only.
module tb_console_capture_panic_detector_top;

    localparam int DEPTH = 16384;
    localparam int HIST_BYTES = 34;
    localparam int PATTERNS = 6;
    localparam int STALL_LIMIT = 2000;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam bit [HIST_BYTES*8-1:0] PATTERN_TEXT [PATTERNS] = '{
        "Illegal instruction in kernel mode",
        "no fault handler for frame",
        "assertion ",
        "kernel panic",
        "Kernel panic",
        "PANIC"
    };
    localparam int PATTERN_LEN [PATTERNS] = '{34, 26, 10, 12, 12, 5};

    localparam int PHASES = 12;
    localparam logic [14:0] LIMIT_PLAN [PHASES] = '{
        15'd0, 15'd1, 15'd2, 15'd34, 15'd200, 15'd5,
        15'd40, 15'd16385, 15'd3, 15'd12, 15'd1000, 15'd16384
    };

    typedef struct packed {
        logic        panic_present;
        logic        was_truncated;
        logic [14:0] stored_length;
        logic        read_valid;
        logic [7:0]  read_data;
    } status_t;

    class capture_window;
        logic [14:0]              limit;
        logic [7:0]               store [DEPTH];
        int unsigned              oldest;
        int unsigned              held;
        bit                       dropped;
        logic [HIST_BYTES*8-1:0]  history;
        bit                       seen;
        int unsigned              span;
        status_t                  status_due [$];
        int                       errors;
        int                       items;
        int                       read_hits;
        int                       panic_beats;

        function new();
            limit = ccpd_pkg::LIMIT_RESET;
            foreach (store[i]) store[i] = '0;
            clear();
            errors = 0;
            items = 0;
            read_hits = 0;
            panic_beats = 0;
        endfunction

        function void clear();
            oldest = 0;
            held = 0;
            dropped = 0;
            history = '0;
            seen = 0;
            span = 0;
        endfunction

        function bit pattern_at_tail(int p);
            for (int k = 0; k < PATTERN_LEN[p]; k++) begin
                if (history[k*8 +: 8] != PATTERN_TEXT[p][k*8 +: 8]) return 0;
            end
            return 1;
        endfunction

        function void push(logic [7:0] b);
            int unsigned lim;
            lim = (limit > DEPTH) ? DEPTH : limit;
            if (lim == 0) return;
            if (held >= lim) begin
                oldest = (oldest + held - lim + 1) % DEPTH;
                held = lim - 1;
                dropped = 1;
            end
            store[(oldest + held) % DEPTH] = b;
            held++;
            history = {history[HIST_BYTES*8-9:0], b};
            if (seen && span <= DEPTH) span++;
            for (int p = 0; p < PATTERNS; p++) begin
                if (pattern_at_tail(p)) begin
                    if (!seen || PATTERN_LEN[p] < span) span = PATTERN_LEN[p];
                    seen = 1;
                end
            end
        endfunction

        function void note_command(logic [1:0] cmd, logic [7:0] b, logic [13:0] off);
            status_t s;
            s = '0;
            case (cmd)
                ccpd_pkg::CMD_PUSH: push(b);
                ccpd_pkg::CMD_READ: begin
                    if (off < held) begin
                        s.read_data = store[(oldest + off) % DEPTH];
                        s.read_valid = 1;
                        read_hits++;
                    end
                end
                ccpd_pkg::CMD_CLEAR: clear();
                default: ;
            endcase
            s.stored_length = 15'(held);
            s.was_truncated = dropped;
            s.panic_present = seen && (span <= held);
            if (s.panic_present) panic_beats++;
            items++;
            status_due.push_back(s);
        endfunction

        function void check_status(logic [31:0] beat);
            status_t got;
            status_t want;
            got = beat[25:0];
            if (status_due.size() == 0) begin
                $error("result beat %h with no command outstanding", beat);
                errors++;
                return;
            end
            want = status_due.pop_front();
            if (got.read_data !== want.read_data) begin
                $error("read_data: expected %0d, got %0d", want.read_data, got.read_data);
                errors++;
            end
            if (got.read_valid !== want.read_valid) begin
                $error("read_valid: expected %0d, got %0d", want.read_valid, got.read_valid);
                errors++;
            end
            if (got.stored_length !== want.stored_length) begin
                $error("stored_length: expected %0d, got %0d",
                       want.stored_length, got.stored_length);
                errors++;
            end
            if (got.was_truncated !== want.was_truncated) begin
                $error("was_truncated: expected %0d, got %0d",
                       want.was_truncated, got.was_truncated);
                errors++;
            end
            if (got.panic_present !== want.panic_present) begin
                $error("panic_present: expected %0d, got %0d",
                       want.panic_present, got.panic_present);
                errors++;
            end
        endfunction

        function int pending();
            return status_due.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [14:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [23:0] s_tdata = '0;      // console_byte[7:0], read_offset[21:8], zero[23:22]
    logic [1:0]  s_tuser = '0;      // cmd[1:0]
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [31:0] m_tdata;           // read_data[7:0], read_valid[8], stored_length[23:9],
                                    // was_truncated[24], panic_present[25], zero[31:26]

    capture_window window = new();
    bit            idling = 1'b1;
    int            stall_left = 0;
    int            quiet = 0;
    int            limit_writes = 0;

    console_capture_panic_detector_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (!idling) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idling && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) window.check_status(m_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                quiet <= 0;
            end else if (quiet >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b, input logic [13:0] off);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b00, off, b};
        do @(posedge aclk); while (!s_tready);
        window.note_command(cmd, b, off);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (window.pending() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [14:0] v);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        window.limit = v;
        limit_writes++;
    endtask

    task automatic push_pattern(input int p, input bit spoil);
        int         cut;
        int         bad;
        logic [7:0] ch;
        cut = PATTERN_LEN[p];
        bad = -1;
        if (spoil) begin
            if ($urandom_range(0, 1)) cut = $urandom_range(1, PATTERN_LEN[p] - 1);
            else bad = $urandom_range(0, PATTERN_LEN[p] - 1);
        end
        for (int i = 0; i < cut; i++) begin
            ch = PATTERN_TEXT[p][(PATTERN_LEN[p] - 1 - i)*8 +: 8];
            if (i == bad) ch = ch ^ 8'h20;
            if (idling && $urandom_range(0, 15) == 0)
                send_item(ccpd_pkg::CMD_READ, 8'($urandom), 14'($urandom));
            send_item(ccpd_pkg::CMD_PUSH, ch, 14'($urandom));
        end
    endtask

    task automatic random_burst();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            push_pattern($urandom_range(0, PATTERNS - 1), $urandom_range(0, 3) == 0);
        end else if (pick < 70) begin
            repeat ($urandom_range(1, 8))
                send_item(ccpd_pkg::CMD_PUSH, 8'($urandom), 14'($urandom));
        end else if (pick < 92) begin
            if (window.held > 0 && $urandom_range(0, 3) != 0)
                send_item(ccpd_pkg::CMD_READ, 8'($urandom),
                          14'($urandom_range(0, window.held - 1)));
            else
                send_item(ccpd_pkg::CMD_READ, 8'($urandom), 14'($urandom));
        end else if (pick < 95) begin
            send_item(ccpd_pkg::CMD_CLEAR, 8'($urandom), 14'($urandom));
        end else begin
            send_item(CMD_SPARE, 8'($urandom), 14'($urandom));
        end
    endtask

    initial begin
        int target;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(ccpd_pkg::CMD_READ, 8'h00, 14'd0);
        send_item(CMD_SPARE, 8'hFF, 14'h3FFF);
        push_pattern(5, 0);
        send_item(ccpd_pkg::CMD_PUSH, 8'h00, 14'h3FFF);
        send_item(ccpd_pkg::CMD_PUSH, 8'hFF, 14'h0000);
        send_item(ccpd_pkg::CMD_READ, 8'h00, 14'd0);
        send_item(ccpd_pkg::CMD_READ, 8'h00, 14'd6);
        send_item(ccpd_pkg::CMD_READ, 8'h00, 14'd7);
        send_item(ccpd_pkg::CMD_READ, 8'hFF, 14'h3FFF);
        send_item(ccpd_pkg::CMD_CLEAR, 8'h00, 14'd0);
        push_pattern(2, 0);

        for (int ph = 0; ph < PHASES; ph++) begin
            set_limit(LIMIT_PLAN[ph]);
            idling = (ph % 4 != 3);
            target = window.items + 120;
            while (window.items < target) random_burst();
        end

        set_limit(15'h7FFF);
        idling = 0;
        send_item(ccpd_pkg::CMD_CLEAR, 8'h00, 14'd0);
        push_pattern(3, 0);
        repeat (24) begin
            send_item(ccpd_pkg::CMD_PUSH, 8'($urandom), 14'($urandom));
            if ($urandom_range(0, 7) == 0)
                send_item(ccpd_pkg::CMD_READ, 8'($urandom),
                          14'($urandom_range(0, window.held - 1)));
        end
        send_item(ccpd_pkg::CMD_READ, 8'h00, 14'd0);
        send_item(ccpd_pkg::CMD_READ, 8'h00, 14'(window.held - 1));
        send_item(ccpd_pkg::CMD_READ, 8'h00, 14'h3FFF);
        idling = 1;

        settle();
        repeat (4) @(posedge aclk);
        $display("%0d commands checked over %0d limit writes, limits above depth included",
                 window.items, limit_writes);
        $display("%0d reads returned data, %0d result beats reported a panic",
                 window.read_hits, window.panic_beats);
        if (window.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ccpd_pkg.sv
rtl/ccpd_front.sv
rtl/ccpd_queue.sv
rtl/ccpd_back.sv
rtl/console_capture_panic_detector_top.sv
tb/tb_console_capture_panic_detector_top.sv
